// ===== src/mcr_pkg.sv =====
// shared types, constants and pixel helpers for the midpoint circle rasterizer
// used by mcr_step, mcr_emit and midpoint_circle_rasterizer_core; no dependencies
package mcr_pkg;

    // screen bounds for the on-screen flag
    localparam int SCREEN_SIZE = 256;

    // field widths
    localparam int COORD_W  = 8;
    localparam int STEP_W   = 9;
    localparam int DEC_W    = 11;
    localparam int PIX_W    = 10;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    // decision increments for the east and south-east moves
    localparam logic [DEC_W:0] DEC_INC_E  = 12'sd3;
    localparam logic [DEC_W:0] DEC_INC_SE = 12'sd5;
    localparam logic [DEC_W:0] DEC_ONE    = 12'sd1;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // last slot index for each job kind
    localparam logic [2:0] LAST_START = 3'd3;
    localparam logic [2:0] LAST_STEP  = 3'd7;
    localparam logic [2:0] LAST_DONE  = 3'd0;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_STEP,
        KIND_DONE
    } t_kind;

    // one queued job: everything needed to emit its results
    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [STEP_W-1:0]  x;
        logic [STEP_W-1:0]  y;
        logic               fin;
    } t_job;

    // one result item
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             has_pixel;
        logic             on_screen;
        logic             last;
        logic             finished;
    } t_pix;

    // axis pixels of a start job reuse the octant slots (x is zero there)
    function automatic logic [2:0] start_slot(input logic [2:0] idx);
        logic [2:0] s;
        case (idx)
            3'd0:    s = 3'd4;
            3'd1:    s = 3'd0;
            3'd2:    s = 3'd6;
            default: s = 3'd1;
        endcase
        return s;
    endfunction

    // center plus or minus an offset, exact in 11 bits
    function automatic logic signed [PIX_W:0] add_off(
        input logic [COORD_W-1:0] c,
        input logic [STEP_W-1:0]  off,
        input logic               neg
    );
        logic signed [PIX_W:0] cs;
        logic signed [PIX_W:0] os;
        cs = $signed({3'b000, c});
        os = $signed({2'b00, off});
        return neg ? (cs - os) : (cs + os);
    endfunction

    // inside the screen when 0 <= v < SCREEN_SIZE
    function automatic logic in_bounds(input logic signed [PIX_W:0] v);
        return !v[PIX_W] && ({22'd0, v[PIX_W-1:0]} < 32'(SCREEN_SIZE));
    endfunction

endpackage

// ===== src/midpoint_circle_rasterizer_core.sv =====
// midpoint circle rasterizer top level: stream ports, state update and pixel emitter
// depends on mcr_pkg, mcr_step and mcr_emit
//
// usage
//   input stream: tuser carries func (start or advance), tdata the center and radius.
//   a start transfer latches center and radius and yields the four axis pixels;
//   each advance transfer runs one octant step and yields eight mirrored pixels;
//   an advance after the circle is complete yields one result without a pixel,
//   with finished and tlast set. off-screen pixels are flagged, not dropped.
//   output stream: one result per transfer, tlast on the final result of an input.
// timing
//   each input is held in the job register and each of its results passes through the
//   output register; results then follow one per cycle while tready is high, since
//   the output port moves one result per cycle.
//   the next input is taken in the cycle its predecessor's last result is loaded.
// reset
//   synchronous active-low reset clears the circle state to zero (so an advance
//   straight after reset reports finished) and empties the job and output registers.
// stall
//   when the receiver holds tready low the output register holds its result, the
//   emitter waits, and the input side stops accepting once the job register is full.
module midpoint_circle_rasterizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // center_x [7:0], center_y [15:8], radius [23:16]
    input  logic [mcr_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tuser,   // func [0]
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pixel_x [9:0], pixel_y [19:10], zero [23:20]
    output logic [mcr_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // has_pixel [0], on_screen [1], finished [2]
    output logic [mcr_pkg::OUT_USER_W-1:0]    o_m_tuser,
    output logic                              o_m_tlast    // last
);

    logic          job_ready;
    logic          accept;
    mcr_pkg::t_job job;
    mcr_pkg::t_pix pix;

    assign o_s_tready = job_ready;
    assign accept     = i_s_tvalid && job_ready;

    // circle state and step arithmetic
    mcr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (i_s_tuser),
        .i_center_x (i_s_tdata[7:0]),
        .i_center_y (i_s_tdata[15:8]),
        .i_radius   (i_s_tdata[23:16]),
        .o_job      (job)
    );

    // pixel sequencing and output register
    mcr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (i_s_tvalid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_pix       (pix)
    );

    // output packing
    assign o_m_tdata = {4'b0000, pix.py, pix.px};
    assign o_m_tuser = {pix.finished, pix.on_screen, pix.has_pixel};
    assign o_m_tlast = pix.last;

endmodule

// ===== src/mcr_step.sv =====
// circle state registers and the per-item midpoint update
// depends on mcr_pkg; produces one job per accepted transfer
module mcr_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_func,
    input  logic [mcr_pkg::COORD_W-1:0] i_center_x,
    input  logic [mcr_pkg::COORD_W-1:0] i_center_y,
    input  logic [mcr_pkg::COORD_W-1:0] i_radius,
    output mcr_pkg::t_job               o_job
);

    logic [mcr_pkg::COORD_W-1:0] r_cx, n_cx;
    logic [mcr_pkg::COORD_W-1:0] r_cy, n_cy;
    logic [mcr_pkg::STEP_W-1:0]  r_x, n_x;
    logic [mcr_pkg::STEP_W-1:0]  r_y, n_y;
    logic [mcr_pkg::DEC_W-1:0]   r_d, n_d;

    logic [mcr_pkg::DEC_W:0] d_ext;
    logic [mcr_pkg::DEC_W:0] x_ext;
    logic [mcr_pkg::DEC_W:0] y_ext;
    logic [mcr_pkg::DEC_W:0] d_sum;
    logic                    active;

    // one midpoint step, a fresh circle on start, or a done job once the circle is complete
    always_comb begin
        d_ext  = {r_d[mcr_pkg::DEC_W-1], r_d};
        x_ext  = {3'b000, r_x};
        y_ext  = {3'b000, r_y};
        active = r_x < r_y;
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_x    = r_x;
        n_y    = r_y;
        d_sum  = d_ext;
        o_job  = '{kind: mcr_pkg::KIND_DONE, cx: r_cx, cy: r_cy,
                   x: r_x, y: r_y, fin: 1'b1};
        if (i_func == mcr_pkg::FUNC_START) begin
            n_cx  = i_center_x;
            n_cy  = i_center_y;
            n_x   = '0;
            n_y   = {1'b0, i_radius};
            d_sum = mcr_pkg::DEC_ONE - {4'b0000, i_radius};
            o_job = '{kind: mcr_pkg::KIND_START, cx: i_center_x, cy: i_center_y,
                       x: '0, y: {1'b0, i_radius}, fin: (i_radius == '0)};
        end else if (active) begin
            if (r_d[mcr_pkg::DEC_W-1]) begin
                d_sum = d_ext + (x_ext << 1) + mcr_pkg::DEC_INC_E;
                n_y   = r_y;
            end else begin
                d_sum = d_ext + ((x_ext - y_ext) << 1) + mcr_pkg::DEC_INC_SE;
                n_y   = r_y - 1'b1;
            end
            n_x   = r_x + 1'b1;
            o_job = '{kind: mcr_pkg::KIND_STEP, cx: r_cx, cy: r_cy,
                       x: n_x, y: n_y, fin: !(n_x < n_y)};
        end
        n_d = d_sum[mcr_pkg::DEC_W-1:0];
    end

    // state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_x  <= '0;
            r_y  <= '0;
            r_d  <= '0;
        end else if (i_accept) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_x  <= n_x;
            r_y  <= n_y;
            r_d  <= n_d;
        end
    end

endmodule

// ===== src/mcr_emit.sv =====
// job register, slot counter and output register that send one result per cycle while tready is high
// depends on mcr_pkg
module mcr_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  mcr_pkg::t_job i_job,
    output logic          o_job_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output mcr_pkg::t_pix o_pix
);

    logic          r_busy;
    mcr_pkg::t_job r_job;
    logic [2:0]    r_idx;
    logic          r_out_valid;
    mcr_pkg::t_pix r_out, n_out;

    logic       out_free;
    logic       emit;
    logic       emit_last;
    logic [2:0] last_idx;
    logic [2:0] slot;
    logic [mcr_pkg::STEP_W-1:0] off_x;
    logic [mcr_pkg::STEP_W-1:0] off_y;
    logic signed [mcr_pkg::PIX_W:0] vx;
    logic signed [mcr_pkg::PIX_W:0] vy;

    // handshake between job register and output register
    always_comb begin
        case (r_job.kind)
            mcr_pkg::KIND_START: last_idx = mcr_pkg::LAST_START;
            mcr_pkg::KIND_STEP:  last_idx = mcr_pkg::LAST_STEP;
            default:             last_idx = mcr_pkg::LAST_DONE;
        endcase
        out_free    = !r_out_valid || i_ready;
        emit        = r_busy && out_free;
        emit_last   = emit && (r_idx == last_idx);
        o_job_ready = !r_busy || emit_last;
    end

    // octant mirroring for the current slot
    always_comb begin
        slot  = (r_job.kind == mcr_pkg::KIND_START) ? mcr_pkg::start_slot(r_idx) : r_idx;
        off_x = slot[2] ? r_job.y : r_job.x;
        off_y = slot[2] ? r_job.x : r_job.y;
        vx    = mcr_pkg::add_off(r_job.cx, off_x, slot[1]);
        vy    = mcr_pkg::add_off(r_job.cy, off_y, slot[0]);
        if (r_job.kind == mcr_pkg::KIND_DONE) begin
            n_out = '{px: '0, py: '0, has_pixel: 1'b0, on_screen: 1'b0,
                      last: 1'b1, finished: 1'b1};
        end else begin
            n_out = '{px: vx[mcr_pkg::PIX_W-1:0], py: vy[mcr_pkg::PIX_W-1:0],
                      has_pixel: 1'b1,
                      on_screen: mcr_pkg::in_bounds(vx) && mcr_pkg::in_bounds(vy),
                      last: (r_idx == last_idx), finished: r_job.fin};
        end
    end

    // job register and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_job_ready && i_job_valid) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit_last) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule
